// ===== rtl/core/gha_pkg.sv =====
// shared types and codes for the generational handle allocator
// no dependencies; imported by the controller, datapath, top level and checker
package gha_pkg;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NOT_LIVE = 2'd1;
    localparam logic [1:0] STS_NO_INDEX = 2'd2;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       live_hit;
        logic       ver_max;
        logic       queue_empty;
        logic       queue_full;
        logic       fresh_left;
    } t_dp_status;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       pop;
        logic       take_fresh;
        logic       live_we;
        logic       live_bit;
        logic       push;
        logic       inc;
        logic       dec;
        logic [1:0] status;
        logic       retired;
    } t_dp_cmd;

endpackage

// ===== rtl/core/gha_ctrl.sv =====
// controller: two-state sequencer, output valid register and operation decode
// depends on gha_pkg
module gha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  gha_pkg::t_dp_status i_sts,
    output gha_pkg::t_dp_cmd  o_cmd
);
    import gha_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_accept;
    logic w_exec;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    // execute once the output register is free or being emptied
    assign w_exec      = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_exec) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        o_cmd.exec = w_exec;
        if (w_exec) begin
            case (i_sts.op)
                OP_CREATE: begin
                    if (!i_sts.queue_empty) begin
                        o_cmd.pop = 1'b1;
                    end else if (i_sts.fresh_left) begin
                        o_cmd.take_fresh = 1'b1;
                    end else begin
                        o_cmd.status = STS_NO_INDEX;
                    end
                    if (!i_sts.queue_empty || i_sts.fresh_left) begin
                        o_cmd.live_we  = 1'b1;
                        o_cmd.live_bit = 1'b1;
                        o_cmd.inc      = 1'b1;
                    end
                end
                OP_DESTROY: begin
                    if (i_sts.live_hit) begin
                        o_cmd.live_we = 1'b1;
                        o_cmd.dec     = 1'b1;
                        if (i_sts.ver_max) begin
                            o_cmd.retired = 1'b1;
                        end else begin
                            o_cmd.push = !i_sts.queue_full;
                        end
                    end else begin
                        o_cmd.status = STS_NOT_LIVE;
                    end
                end
                OP_LOOKUP: begin
                    if (!i_sts.live_hit) begin
                        o_cmd.status = STS_NOT_LIVE;
                    end
                end
                default: o_cmd.status = STS_OK;
            endcase
        end
    end

endmodule

// ===== rtl/core/gha_dp.sv =====
// datapath: live table and free queue memories, pointers, counters, result register
// depends on gha_pkg
module gha_dp #(
    parameter int INDEX_WIDTH   = 8,
    parameter int VERSION_WIDTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_op,
    input  logic [15:0]         i_handle,
    input  gha_pkg::t_dp_cmd    i_cmd,
    output gha_pkg::t_dp_status o_sts,
    output logic [15:0]         o_handle,
    output logic [1:0]          o_status,
    output logic                o_retired,
    output logic [8:0]          o_live_count
);
    import gha_pkg::*;

    localparam int IW    = INDEX_WIDTH;
    localparam int VW    = VERSION_WIDTH;
    localparam int HW    = IW + VW;
    localparam int EXT_W = (HW > 16) ? HW : 16;
    localparam int NUM   = 2 ** IW;

    // live table entry: live bit above version
    logic [VW:0]   mem_live [NUM];
    logic [HW-1:0] mem_q    [NUM];

    logic [EXT_W-1:0] w_ext;
    logic [HW-1:0]    w_h;
    logic [1:0]       r_op;
    logic [15:0]      r_raw;
    logic [HW-1:0]    r_handle;
    logic [VW:0]      r_live_rd;
    logic [HW-1:0]    r_q_rd;
    logic [IW-1:0]    r_head;
    logic [IW-1:0]    r_tail;
    logic [IW:0]      r_fill;
    logic [IW:0]      r_fresh;
    logic [IW:0]      r_total;
    logic [IW:0]      n_total;
    logic [HW-1:0]    w_new_h;
    logic [IW-1:0]    w_idx;
    logic [VW-1:0]    w_ver;
    logic [IW-1:0]    w_wr_idx;
    logic [VW-1:0]    w_wr_ver;
    logic [HW-1:0]    w_push_h;
    logic [15:0]      r_o_handle;
    logic [1:0]       r_o_status;
    logic             r_o_retired;
    logic [8:0]       r_o_count;

    assign w_ext = EXT_W'(i_handle);
    assign w_h   = w_ext[HW-1:0];
    assign w_idx = r_handle[HW-1:VW];
    assign w_ver = r_handle[VW-1:0];

    // indices at or above the fresh counter were not handed out since reset,
    // so their table entries read as not live without any clearing pass
    assign o_sts.op          = r_op;
    assign o_sts.live_hit    = ({1'b0, w_idx} < r_fresh) && r_live_rd[VW]
                               && (r_live_rd[VW-1:0] == w_ver);
    assign o_sts.ver_max     = &w_ver;
    assign o_sts.queue_empty = (r_fill == '0);
    assign o_sts.queue_full  = r_fill[IW];
    assign o_sts.fresh_left  = !r_fresh[IW];

    assign w_new_h  = i_cmd.pop ? r_q_rd : {r_fresh[IW-1:0], {VW{1'b0}}};
    assign w_wr_idx = (r_op == OP_CREATE) ? w_new_h[HW-1:VW] : w_idx;
    assign w_wr_ver = (r_op == OP_CREATE) ? w_new_h[VW-1:0] : w_ver;
    assign w_push_h = {w_idx, VW'(w_ver + 1'b1)};

    always_comb begin
        n_total = r_total;
        if (i_cmd.inc) begin
            n_total = r_total + 1'b1;
        end else if (i_cmd.dec) begin
            n_total = r_total - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_raw     <= i_handle;
            r_handle  <= w_h;
            r_live_rd <= mem_live[w_h[HW-1:VW]];
            r_q_rd    <= mem_q[r_head];
        end
        if (i_cmd.live_we) begin
            mem_live[w_wr_idx] <= {i_cmd.live_bit, w_wr_ver};
        end
        if (i_cmd.push) begin
            mem_q[r_tail] <= w_push_h;
        end
        if (i_cmd.exec) begin
            r_o_status  <= i_cmd.status;
            r_o_retired <= i_cmd.retired;
            r_o_count   <= 9'(n_total);
            if (i_cmd.status == STS_NO_INDEX) begin
                r_o_handle <= '0;
            end else if (r_op == OP_CREATE) begin
                r_o_handle <= 16'(w_new_h);
            end else begin
                r_o_handle <= r_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_fresh <= '0;
            r_total <= '0;
        end else begin
            r_total <= n_total;
            if (i_cmd.pop) begin
                r_head <= r_head + 1'b1;
            end
            if (i_cmd.push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_cmd.take_fresh) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (i_cmd.pop && !i_cmd.push) begin
                r_fill <= r_fill - 1'b1;
            end else if (i_cmd.push && !i_cmd.pop) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_handle     = r_o_handle;
    assign o_status     = r_o_status;
    assign o_retired    = r_o_retired;
    assign o_live_count = r_o_count;

endmodule

// ===== rtl/core/generational_handle_allocator_unit.sv =====
// channel | direction | tdata fields (lowest bit up)
// s_axis  | in        | operation[1:0], handle_in[17:2], zero fill to 24 bits
// m_axis  | out       | handle_out[15:0], status[17:16], retired[18],
//         |           | live_count[27:19], zero fill to 32 bits
// an item is accepted in idle with its table and queue read, then updated in exec, which registers the result
// this split keeps the single-port live table and free queue memories to one access at a time
// a new item is taken while the previous result waits; execution stalls on m_axis
// reset is immediate: no clearing pass, the fresh index counter masks stale entries
//
// top level of the generational handle allocator
// depends on gha_pkg, gha_ctrl and gha_dp
module generational_handle_allocator_unit #(
    parameter int INDEX_WIDTH   = 8,
    parameter int VERSION_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // operation, handle_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // handle_out, status, retired, live_count
);
    import gha_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;
    logic [15:0] w_handle;
    logic [1:0]  w_status;
    logic        w_retired;
    logic [8:0]  w_count;

    gha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gha_dp #(
        .INDEX_WIDTH   (INDEX_WIDTH),
        .VERSION_WIDTH (VERSION_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (s_axis_tdata[1:0]),
        .i_handle     (s_axis_tdata[17:2]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_handle     (w_handle),
        .o_status     (w_status),
        .o_retired    (w_retired),
        .o_live_count (w_count)
    );

    assign m_axis_tdata = {4'b0000, w_count, w_retired, w_status, w_handle};

endmodule

// ===== rtl/core/gha_checker.sv =====
// port-level checks for the generational handle allocator
// depends on gha_pkg and generational_handle_allocator_unit, attached by bind
module gha_checker #(
    parameter int INDEX_WIDTH = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import gha_pkg::*;

    localparam logic [9:0] MAX_LIVE = 10'(2 ** INDEX_WIDTH);

    // one transaction in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_retired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[17:16] == STS_OK)
        else $error("retired flag on a failed operation");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[27:19]} <= MAX_LIVE
            && m_axis_tdata[17:16] <= STS_NO_INDEX)
        else $error("live count or status out of range");

    // a failed create reports the null handle
    a_no_index_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == STS_NO_INDEX
            |-> m_axis_tdata[15:0] == 16'd0)
        else $error("out of indices with non-null handle");

endmodule

bind generational_handle_allocator_unit gha_checker #(
    .INDEX_WIDTH (INDEX_WIDTH)
) u_gha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
